[sv/c8_pkg.sv]
package c8_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int FONT_BASE   = 80;
  localparam int SCREEN_COLS = 64;
  localparam int SCREEN_ROWS = 32;

  localparam int ADDR_W    = 12;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int SP_W      = $clog2(STACK_DEPTH + 1);
  localparam int SP_IW     = $clog2(STACK_DEPTH);
  localparam int ROW_IW    = $clog2(SCREEN_ROWS);
  localparam int COL_IW    = $clog2(SCREEN_COLS);
  localparam int CNT_W     = 5;

  localparam logic [ADDR_W-1:0] PC_START = 12'h200;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_RUN  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_OVER  = 2'd1;
  localparam logic [1:0] FAULT_UNDER = 2'd2;

  localparam logic [15:0] OP_CLS = 16'h00e0;
  localparam logic [15:0] OP_RET = 16'h00ee;

  localparam logic [3:0] K_SYS  = 4'h0;
  localparam logic [3:0] K_JP   = 4'h1;
  localparam logic [3:0] K_CALL = 4'h2;
  localparam logic [3:0] K_SEQI = 4'h3;
  localparam logic [3:0] K_SNEI = 4'h4;
  localparam logic [3:0] K_SEQ  = 4'h5;
  localparam logic [3:0] K_LDI  = 4'h6;
  localparam logic [3:0] K_ADDI = 4'h7;
  localparam logic [3:0] K_ALU  = 4'h8;
  localparam logic [3:0] K_SNE  = 4'h9;
  localparam logic [3:0] K_LDIX = 4'ha;
  localparam logic [3:0] K_JPV  = 4'hb;
  localparam logic [3:0] K_RND  = 4'hc;
  localparam logic [3:0] K_DRW  = 4'hd;
  localparam logic [3:0] K_KEY  = 4'he;
  localparam logic [3:0] K_MISC = 4'hf;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'he;

  localparam logic [7:0] NN_SKP   = 8'h9e;
  localparam logic [7:0] NN_SKNP  = 8'ha1;
  localparam logic [7:0] NN_GETDT = 8'h07;
  localparam logic [7:0] NN_WAITK = 8'h0a;
  localparam logic [7:0] NN_SETDT = 8'h15;
  localparam logic [7:0] NN_SETST = 8'h18;
  localparam logic [7:0] NN_ADDIX = 8'h1e;
  localparam logic [7:0] NN_FONT  = 8'h29;
  localparam logic [7:0] NN_BCD   = 8'h33;
  localparam logic [7:0] NN_STORE = 8'h55;
  localparam logic [7:0] NN_LOAD  = 8'h65;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRITE, ST_TICK, ST_FETCH_LO, ST_LATCH_LO, ST_EXEC,
    ST_DRAW_RD, ST_DRAW_WR, ST_BCD, ST_STORE, ST_LOAD_RD, ST_LOAD_WR, ST_DONE
  } state_t;

  typedef enum logic [1:0] {RS_PC, RS_PC1, RS_IDX} rd_src_t;
  typedef enum logic [1:0] {WS_LOAD, WS_BCD, WS_VREG} wr_src_t;

  typedef struct packed {
    logic             capture;
    logic             mem_we;
    wr_src_t          wr_src;
    rd_src_t          rd_src;
    logic             latch_hi;
    logic             latch_lo;
    logic             tick;
    logic             pc_inc;
    logic             exec;
    logic             hit_clr;
    logic             draw_row;
    logic             draw_fin;
    logic             vload;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic [15:0] op;
    logic        draw_more;
  } status_t;

endpackage

[sv/c8_ctrl.sv]
module c8_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [1:0]      in_action,
  input  c8_pkg::status_t sts,
  output c8_pkg::cmd_t    cmd,
  output logic            busy,
  output logic            out_valid
);

  c8_pkg::state_t state_r, state_nxt;
  logic [c8_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0] kind, x;
  logic [7:0] nn;

  assign kind = sts.op[15:12];
  assign x    = sts.op[11:8];
  assign nn   = sts.op[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= c8_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.wr_src  = c8_pkg::WS_LOAD;
    cmd.rd_src  = c8_pkg::RS_PC;
    cmd.cnt     = cnt_r;
    busy        = (state_r != c8_pkg::ST_IDLE);
    out_valid   = 1'b0;
    unique case (state_r)
      c8_pkg::ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          cnt_nxt     = '0;
          priority if (in_action == c8_pkg::ACT_LOAD) state_nxt = c8_pkg::ST_WRITE;
          else if (in_action == c8_pkg::ACT_RUN) state_nxt = c8_pkg::ST_TICK;
          else state_nxt = c8_pkg::ST_DONE;
        end
      end
      c8_pkg::ST_WRITE: begin
        cmd.mem_we = 1'b1;
        state_nxt  = c8_pkg::ST_DONE;
      end
      c8_pkg::ST_TICK: begin
        cmd.tick  = 1'b1;
        state_nxt = c8_pkg::ST_FETCH_LO;
      end
      c8_pkg::ST_FETCH_LO: begin
        cmd.latch_hi = 1'b1;
        cmd.rd_src   = c8_pkg::RS_PC1;
        state_nxt    = c8_pkg::ST_LATCH_LO;
      end
      c8_pkg::ST_LATCH_LO: begin
        cmd.latch_lo = 1'b1;
        cmd.pc_inc   = 1'b1;
        state_nxt    = c8_pkg::ST_EXEC;
      end
      c8_pkg::ST_EXEC: begin
        priority if (kind == c8_pkg::K_DRW) begin
          cmd.hit_clr = 1'b1;
          state_nxt   = c8_pkg::ST_DRAW_RD;
        end else if (kind == c8_pkg::K_MISC && nn == c8_pkg::NN_BCD) begin
          state_nxt = c8_pkg::ST_BCD;
        end else if (kind == c8_pkg::K_MISC && nn == c8_pkg::NN_STORE) begin
          state_nxt = c8_pkg::ST_STORE;
        end else if (kind == c8_pkg::K_MISC && nn == c8_pkg::NN_LOAD) begin
          state_nxt = c8_pkg::ST_LOAD_RD;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = c8_pkg::ST_DONE;
        end
      end
      c8_pkg::ST_DRAW_RD: begin
        cmd.rd_src = c8_pkg::RS_IDX;
        if (sts.draw_more) begin
          state_nxt = c8_pkg::ST_DRAW_WR;
        end else begin
          cmd.draw_fin = 1'b1;
          state_nxt    = c8_pkg::ST_DONE;
        end
      end
      c8_pkg::ST_DRAW_WR: begin
        cmd.draw_row = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        state_nxt    = c8_pkg::ST_DRAW_RD;
      end
      c8_pkg::ST_BCD: begin
        cmd.mem_we = 1'b1;
        cmd.wr_src = c8_pkg::WS_BCD;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == c8_pkg::CNT_W'(2)) state_nxt = c8_pkg::ST_DONE;
      end
      c8_pkg::ST_STORE: begin
        cmd.mem_we = 1'b1;
        cmd.wr_src = c8_pkg::WS_VREG;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r[3:0] == x) state_nxt = c8_pkg::ST_DONE;
      end
      c8_pkg::ST_LOAD_RD: begin
        cmd.rd_src = c8_pkg::RS_IDX;
        state_nxt  = c8_pkg::ST_LOAD_WR;
      end
      c8_pkg::ST_LOAD_WR: begin
        cmd.vload = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r[3:0] == x) state_nxt = c8_pkg::ST_DONE;
        else state_nxt = c8_pkg::ST_LOAD_RD;
      end
      c8_pkg::ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = c8_pkg::ST_IDLE;
      end
      default: state_nxt = c8_pkg::ST_IDLE;
    endcase
  end

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request accepted but core not busy");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> cnt_r <= c8_pkg::CNT_W'(16)) else $error("step counter out of range");

endmodule

[sv/c8_datapath.sv]
module c8_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  c8_pkg::cmd_t    cmd,
  input  logic [1:0]      in_action,
  input  logic [11:0]     in_address,
  input  logic [7:0]      in_data,
  input  logic [15:0]     in_keys_pressed,
  input  logic [7:0]      in_random_value,
  output c8_pkg::status_t sts,
  output logic [11:0]     out_pc_now,
  output logic            out_sound_on,
  output logic            out_screen_changed,
  output logic            out_waiting_for_key,
  output logic [63:0]     out_screen_row,
  output logic [1:0]      out_fault
);

  logic [7:0]  mem [c8_pkg::MEM_DEPTH];
  logic [7:0]  mem_q_r;
  logic [7:0]  v_r [16];
  logic [63:0] fb_r [c8_pkg::SCREEN_ROWS];
  logic [11:0] stk_r [c8_pkg::STACK_DEPTH];
  logic [c8_pkg::SP_W-1:0] sp_r;
  logic [11:0] pc_r, idx_r, addr_r;
  logic [7:0]  dt_r, st_r, data_r, rnd_r, hi_r, lo_r;
  logic [15:0] keys_r;
  logic [1:0]  act_r, fault_r;
  logic        changed_r, wait_r, hit_r;

  logic [15:0] op;
  logic [3:0]  kind, x, y, n;
  logic [7:0]  nn, vx, vy;
  logic [11:0] nnn, rd_addr, wr_addr, idx_off;
  logic [7:0]  wr_data;
  logic [5:0]  draw_sum;
  logic [63:0] spr;
  logic [c8_pkg::ROW_IW-1:0] draw_idx;
  logic [8:0]  alu_sum;
  logic [7:0]  alu_res;
  logic        alu_f, alu_we, alu_fwe;
  logic [3:0]  key_num;
  logic        key_found;
  logic [12:0] ix_sum;
  logic [1:0]  bcd_h;
  logic [6:0]  bcd_rem;
  logic [3:0]  bcd_t, bcd_o;
  logic [14:0] bcd_prod;

  assign op   = {hi_r, lo_r};
  assign kind = op[15:12];
  assign x    = op[11:8];
  assign y    = op[7:4];
  assign n    = op[3:0];
  assign nn   = op[7:0];
  assign nnn  = op[11:0];
  assign vx   = v_r[x];
  assign vy   = v_r[y];

  assign idx_off = idx_r + 12'(cmd.cnt);

  always_comb begin
    unique case (cmd.rd_src)
      c8_pkg::RS_PC:  rd_addr = pc_r;
      c8_pkg::RS_PC1: rd_addr = pc_r + 12'd1;
      default:        rd_addr = idx_off;
    endcase
  end

  // Decimal digits: hundreds by compare, tens by reciprocal multiply (exact below 100).
  always_comb begin
    bcd_h    = (vx >= 8'd200) ? 2'd2 : ((vx >= 8'd100) ? 2'd1 : 2'd0);
    bcd_rem  = 7'(vx - 8'(bcd_h) * 8'd100);
    bcd_prod = 15'(bcd_rem) * 15'd205;
    bcd_t    = bcd_prod[14:11];
    bcd_o    = 4'(bcd_rem - 7'(bcd_t) * 7'd10);
  end

  always_comb begin
    wr_addr = idx_off;
    unique case (cmd.wr_src)
      c8_pkg::WS_LOAD: begin
        wr_addr = addr_r;
        wr_data = data_r;
      end
      c8_pkg::WS_BCD: begin
        priority case (cmd.cnt[1:0])
          2'd0:    wr_data = 8'(bcd_h);
          2'd1:    wr_data = 8'(bcd_t);
          default: wr_data = 8'(bcd_o);
        endcase
      end
      default: wr_data = v_r[cmd.cnt[3:0]];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) mem[wr_addr] <= wr_data;
    mem_q_r <= mem[rd_addr];
  end

  always_comb begin
    alu_sum = 9'(vx) + 9'(vy);
    alu_we  = 1'b1;
    alu_fwe = 1'b1;
    alu_res = vy;
    alu_f   = 1'b0;
    unique case (n)
      c8_pkg::ALU_MOV: begin alu_res = vy;      alu_fwe = 1'b0; end
      c8_pkg::ALU_OR:  begin alu_res = vx | vy; alu_fwe = 1'b0; end
      c8_pkg::ALU_AND: begin alu_res = vx & vy; alu_fwe = 1'b0; end
      c8_pkg::ALU_XOR: begin alu_res = vx ^ vy; alu_fwe = 1'b0; end
      c8_pkg::ALU_ADD: begin alu_res = alu_sum[7:0]; alu_f = alu_sum[8]; end
      c8_pkg::ALU_SUB: begin alu_res = vx - vy; alu_f = (vx >= vy); end
      c8_pkg::ALU_SHR: begin alu_res = {1'b0, vx[7:1]}; alu_f = vx[0]; end
      c8_pkg::ALU_SBN: begin alu_res = vy - vx; alu_f = (vy >= vx); end
      c8_pkg::ALU_SHL: begin alu_res = {vx[6:0], 1'b0}; alu_f = vx[7]; end
      default: begin alu_we = 1'b0; alu_fwe = 1'b0; end
    endcase
  end

  always_comb begin
    key_num   = '0;
    key_found = 1'b0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_r[k]) begin
        key_num   = 4'(k);
        key_found = 1'b1;
      end
    end
  end

  assign ix_sum   = 13'(idx_r) + 13'(vx);
  assign draw_sum = 6'(vy[c8_pkg::ROW_IW-1:0]) + 6'(cmd.cnt);
  assign draw_idx = draw_sum[c8_pkg::ROW_IW-1:0];
  assign spr      = {mem_q_r, 56'd0} >> vx[c8_pkg::COL_IW-1:0];

  assign sts.op        = op;
  assign sts.draw_more = (cmd.cnt < 5'(n)) && (draw_sum < 6'(c8_pkg::SCREEN_ROWS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) v_r[i] <= '0;
      for (int i = 0; i < c8_pkg::SCREEN_ROWS; i++) fb_r[i] <= '0;
      pc_r      <= c8_pkg::PC_START;
      idx_r     <= '0;
      sp_r      <= '0;
      dt_r      <= '0;
      st_r      <= '0;
      act_r     <= c8_pkg::ACT_LOAD;
      fault_r   <= c8_pkg::FAULT_NONE;
      changed_r <= 1'b0;
      wait_r    <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      if (cmd.capture) begin
        act_r     <= in_action;
        addr_r    <= in_address;
        data_r    <= in_data;
        keys_r    <= in_keys_pressed;
        rnd_r     <= in_random_value;
        fault_r   <= c8_pkg::FAULT_NONE;
        changed_r <= 1'b0;
        wait_r    <= 1'b0;
      end
      if (cmd.tick) begin
        if (dt_r != 8'd0) dt_r <= dt_r - 8'd1;
        if (st_r != 8'd0) st_r <= st_r - 8'd1;
      end
      if (cmd.latch_hi) hi_r <= mem_q_r;
      if (cmd.latch_lo) lo_r <= mem_q_r;
      if (cmd.pc_inc) pc_r <= pc_r + 12'd2;
      if (cmd.hit_clr) hit_r <= 1'b0;
      if (cmd.draw_row) begin
        if ((fb_r[draw_idx] & spr) != 64'd0) hit_r <= 1'b1;
        fb_r[draw_idx] <= fb_r[draw_idx] ^ spr;
      end
      if (cmd.draw_fin) begin
        v_r[15]   <= {7'd0, hit_r};
        changed_r <= 1'b1;
      end
      if (cmd.vload) v_r[cmd.cnt[3:0]] <= mem_q_r;
      if (cmd.exec) begin
        unique case (kind)
          c8_pkg::K_SYS: begin
            if (op == c8_pkg::OP_CLS) begin
              for (int i = 0; i < c8_pkg::SCREEN_ROWS; i++) fb_r[i] <= '0;
              changed_r <= 1'b1;
            end else if (op == c8_pkg::OP_RET) begin
              if (sp_r == '0) begin
                fault_r <= c8_pkg::FAULT_UNDER;
              end else begin
                sp_r <= sp_r - 1'b1;
                pc_r <= stk_r[c8_pkg::SP_IW'(sp_r - 1'b1)];
              end
            end
          end
          c8_pkg::K_JP: pc_r <= nnn;
          c8_pkg::K_CALL: begin
            if (sp_r >= c8_pkg::SP_W'(c8_pkg::STACK_DEPTH)) begin
              fault_r <= c8_pkg::FAULT_OVER;
            end else begin
              stk_r[sp_r[c8_pkg::SP_IW-1:0]] <= pc_r;
              sp_r <= sp_r + 1'b1;
              pc_r <= nnn;
            end
          end
          c8_pkg::K_SEQI: if (vx == nn) pc_r <= pc_r + 12'd2;
          c8_pkg::K_SNEI: if (vx != nn) pc_r <= pc_r + 12'd2;
          c8_pkg::K_SEQ:  if (n == 4'd0 && vx == vy) pc_r <= pc_r + 12'd2;
          c8_pkg::K_SNE:  if (n == 4'd0 && vx != vy) pc_r <= pc_r + 12'd2;
          c8_pkg::K_LDI:  v_r[x] <= nn;
          c8_pkg::K_ADDI: v_r[x] <= vx + nn;
          c8_pkg::K_ALU: begin
            // With VF as the target of a flag-setting operation the flag wins, so the result is not written.
            if (alu_we && !(alu_fwe && x == 4'd15)) v_r[x] <= alu_res;
            if (alu_fwe) v_r[15] <= {7'd0, alu_f};
          end
          c8_pkg::K_LDIX: idx_r <= nnn;
          c8_pkg::K_JPV:  pc_r <= 12'(vx) + nnn;
          c8_pkg::K_RND:  v_r[x] <= rnd_r & nn;
          c8_pkg::K_KEY: begin
            if ((nn == c8_pkg::NN_SKP && keys_r[vx[3:0]]) ||
                (nn == c8_pkg::NN_SKNP && !keys_r[vx[3:0]])) pc_r <= pc_r + 12'd2;
          end
          c8_pkg::K_MISC: begin
            priority case (nn)
              c8_pkg::NN_GETDT: v_r[x] <= dt_r;
              c8_pkg::NN_SETDT: dt_r <= vx;
              c8_pkg::NN_SETST: st_r <= vx;
              c8_pkg::NN_ADDIX: begin
                idx_r   <= ix_sum[11:0];
                v_r[15] <= {7'd0, ix_sum[12]};
              end
              c8_pkg::NN_WAITK: begin
                if (key_found) begin
                  v_r[x] <= {4'd0, key_num};
                end else begin
                  pc_r   <= pc_r - 12'd2;
                  wait_r <= 1'b1;
                end
              end
              c8_pkg::NN_FONT:
                idx_r <= 12'(c8_pkg::FONT_BASE) + 12'({vx, 2'b00}) + 12'(vx);
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  assign out_pc_now          = pc_r;
  assign out_sound_on        = (st_r != 8'd0);
  assign out_screen_changed  = changed_r;
  assign out_waiting_for_key = wait_r;
  assign out_fault           = fault_r;
  assign out_screen_row      = (act_r == c8_pkg::ACT_READ &&
                                addr_r < 12'(c8_pkg::SCREEN_ROWS)) ?
                               fb_r[addr_r[c8_pkg::ROW_IW-1:0]] : 64'd0;

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= c8_pkg::SP_W'(c8_pkg::STACK_DEPTH)) else $error("stack pointer out of range");

endmodule

[sv/chip8_interpreter_core_unit.sv]
// CHIP-8 core. Raise start with a request while busy is low; the request is
// taken at that edge and busy stays high until its result has been shown.
// The result appears for exactly one cycle with out_valid high and cannot be
// held off. A memory load passes a write state; a row read goes straight to the
// result. An instruction passes timer tick, fetch of both opcode bytes and
// execute, then a write step per BCD digit or stored register, a read and a
// write step per loaded register or sprite row, a last read for a draw. The
// 4 KB memory's registered read sets the steps. No clearing pass follows reset.
module chip8_interpreter_core_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [15:0] in_keys_pressed,
  input  logic [7:0]  in_random_value,
  output logic        out_valid,
  output logic [11:0] out_pc_now,
  output logic        out_sound_on,
  output logic        out_screen_changed,
  output logic        out_waiting_for_key,
  output logic [63:0] out_screen_row,
  output logic [1:0]  out_fault
);

  c8_pkg::cmd_t    cmd;
  c8_pkg::status_t sts;

  c8_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  c8_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_action           (in_action),
    .in_address          (in_address),
    .in_data             (in_data),
    .in_keys_pressed     (in_keys_pressed),
    .in_random_value     (in_random_value),
    .sts                 (sts),
    .out_pc_now          (out_pc_now),
    .out_sound_on        (out_sound_on),
    .out_screen_changed  (out_screen_changed),
    .out_waiting_for_key (out_waiting_for_key),
    .out_screen_row      (out_screen_row),
    .out_fault           (out_fault)
  );

endmodule

[verif/chip8_interpreter_core_checker.sv]
module chip8_interpreter_core_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_action,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [15:0] in_keys_pressed,
  input  logic [7:0]  in_random_value,
  input  logic        out_valid,
  input  logic [11:0] out_pc_now,
  input  logic        out_sound_on,
  input  logic        out_screen_changed,
  input  logic        out_waiting_for_key,
  input  logic [63:0] out_screen_row,
  input  logic [1:0]  out_fault,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [11:0] pc_now;
    logic        sound_on;
    logic        screen_changed;
    logic        waiting_for_key;
    logic [63:0] screen_row;
    logic [1:0]  fault;
  } core_result_t;

  core_result_t result_q[$];

  logic [7:0]  mem_m [c8_pkg::MEM_DEPTH];
  logic [7:0]  v_m [16];
  logic [11:0] idx_m;
  logic [11:0] pc_m;
  logic [11:0] stack_m [c8_pkg::STACK_DEPTH];
  int          sp_m;
  logic [7:0]  delay_m;
  logic [7:0]  sound_m;
  logic [63:0] fb_m [c8_pkg::SCREEN_ROWS];

  initial begin
    fail_count = 0;
    pending_count = 0;
    for (int a = 0; a < c8_pkg::MEM_DEPTH; a++) mem_m[a] = 8'h00;
    for (int r = 0; r < 16; r++) v_m[r] = 8'h00;
    for (int r = 0; r < c8_pkg::SCREEN_ROWS; r++) fb_m[r] = 64'h0;
    for (int r = 0; r < c8_pkg::STACK_DEPTH; r++) stack_m[r] = 12'h0;
    idx_m = 12'h0;
    pc_m = c8_pkg::PC_START;
    sp_m = 0;
    delay_m = 8'h00;
    sound_m = 8'h00;
  end

  // Executes one instruction on the shadow core state and builds the result.
  task automatic predict_cycle(input logic [15:0] keys, input logic [7:0] rnd,
                               inout core_result_t res);
    logic [15:0] op;
    logic [3:0]  kind, x, y, n;
    logic [7:0]  nn, vx, vy;
    logic [11:0] nnn;
    logic [8:0]  wide;
    logic [12:0] sum;
    logic [63:0] spr;
    logic [5:0]  col;
    logic [4:0]  row;
    logic        hit, held, found;
    if (delay_m != 0) delay_m = delay_m - 1;
    if (sound_m != 0) sound_m = sound_m - 1;
    op = {mem_m[pc_m], mem_m[pc_m + 12'd1]};
    pc_m = pc_m + 12'd2;
    kind = op[15:12]; x = op[11:8]; y = op[7:4]; n = op[3:0];
    nn = op[7:0]; nnn = op[11:0];
    vx = v_m[x]; vy = v_m[y];
    case (kind)
      c8_pkg::K_SYS: begin
        if (op == c8_pkg::OP_CLS) begin
          for (int r = 0; r < c8_pkg::SCREEN_ROWS; r++) fb_m[r] = 64'h0;
          res.screen_changed = 1'b1;
        end else if (op == c8_pkg::OP_RET) begin
          if (sp_m == 0) res.fault = c8_pkg::FAULT_UNDER;
          else begin
            sp_m--;
            pc_m = stack_m[sp_m];
          end
        end
      end
      c8_pkg::K_JP: pc_m = nnn;
      c8_pkg::K_CALL: begin
        if (sp_m >= c8_pkg::STACK_DEPTH) res.fault = c8_pkg::FAULT_OVER;
        else begin
          stack_m[sp_m] = pc_m;
          sp_m++;
          pc_m = nnn;
        end
      end
      c8_pkg::K_SEQI: if (vx == nn) pc_m = pc_m + 12'd2;
      c8_pkg::K_SNEI: if (vx != nn) pc_m = pc_m + 12'd2;
      c8_pkg::K_SEQ:  if (n == 4'h0 && vx == vy) pc_m = pc_m + 12'd2;
      c8_pkg::K_LDI:  v_m[x] = nn;
      c8_pkg::K_ADDI: v_m[x] = vx + nn;
      c8_pkg::K_ALU: begin
        case (n)
          c8_pkg::ALU_MOV: v_m[x] = vy;
          c8_pkg::ALU_OR:  v_m[x] = vx | vy;
          c8_pkg::ALU_AND: v_m[x] = vx & vy;
          c8_pkg::ALU_XOR: v_m[x] = vx ^ vy;
          c8_pkg::ALU_ADD: begin
            wide = vx + vy;
            v_m[x] = wide[7:0]; v_m[15] = {7'd0, wide[8]};
          end
          c8_pkg::ALU_SUB: begin v_m[x] = vx - vy; v_m[15] = {7'd0, vx >= vy}; end
          c8_pkg::ALU_SHR: begin v_m[x] = vx >> 1; v_m[15] = {7'd0, vx[0]}; end
          c8_pkg::ALU_SBN: begin v_m[x] = vy - vx; v_m[15] = {7'd0, vy >= vx}; end
          c8_pkg::ALU_SHL: begin v_m[x] = vx << 1; v_m[15] = {7'd0, vx[7]}; end
          default: ;
        endcase
      end
      c8_pkg::K_SNE:  if (n == 4'h0 && vx != vy) pc_m = pc_m + 12'd2;
      c8_pkg::K_LDIX: idx_m = nnn;
      c8_pkg::K_JPV:  pc_m = {4'h0, vx} + nnn;
      c8_pkg::K_RND:  v_m[x] = rnd & nn;
      c8_pkg::K_DRW: begin
        col = vx[5:0];
        row = vy[4:0];
        hit = 1'b0;
        for (int i = 0; i < n && row + i < c8_pkg::SCREEN_ROWS; i++) begin
          spr = {mem_m[idx_m + 12'(i)], 56'h0} >> col;
          if ((fb_m[row + i] & spr) != 0) hit = 1'b1;
          fb_m[row + i] ^= spr;
        end
        v_m[15] = {7'd0, hit};
        res.screen_changed = 1'b1;
      end
      c8_pkg::K_KEY: begin
        held = keys[vx[3:0]];
        if ((nn == c8_pkg::NN_SKP && held) || (nn == c8_pkg::NN_SKNP && !held))
          pc_m = pc_m + 12'd2;
      end
      default: begin
        case (nn)
          c8_pkg::NN_GETDT: v_m[x] = delay_m;
          c8_pkg::NN_SETDT: delay_m = vx;
          c8_pkg::NN_SETST: sound_m = vx;
          c8_pkg::NN_ADDIX: begin
            sum = idx_m + vx;
            idx_m = sum[11:0];
            v_m[15] = {7'd0, sum[12]};
          end
          c8_pkg::NN_WAITK: begin
            found = 1'b0;
            for (int k = 0; k < 16; k++) begin
              if (!found && keys[k]) begin
                v_m[x] = 8'(k);
                found = 1'b1;
              end
            end
            if (!found) begin
              pc_m = pc_m - 12'd2;
              res.waiting_for_key = 1'b1;
            end
          end
          c8_pkg::NN_FONT: idx_m = 12'(c8_pkg::FONT_BASE + vx * 5);
          c8_pkg::NN_BCD: begin
            mem_m[idx_m] = vx / 100;
            mem_m[idx_m + 12'd1] = (vx / 10) % 10;
            mem_m[idx_m + 12'd2] = vx % 10;
          end
          c8_pkg::NN_STORE:
            for (int i = 0; i <= x; i++) mem_m[idx_m + 12'(i)] = v_m[i];
          c8_pkg::NN_LOAD:
            for (int i = 0; i <= x; i++) v_m[i] = mem_m[idx_m + 12'(i)];
          default: ;
        endcase
      end
    endcase
  endtask

  always @(posedge clk) begin
    core_result_t want, got;
    if (rst_n && out_valid) begin
      got = '{out_pc_now, out_sound_on, out_screen_changed, out_waiting_for_key,
              out_screen_row, out_fault};
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result pc=%h", $time, out_pc_now);
        fail_count++;
      end else begin
        want = result_q.pop_front();
        if (got.pc_now !== want.pc_now) begin
          $display("%0t: pc_now expected %h actual %h", $time, want.pc_now, got.pc_now);
          fail_count++;
        end
        if (got.sound_on !== want.sound_on) begin
          $display("%0t: sound_on expected %b actual %b", $time, want.sound_on,
                   got.sound_on);
          fail_count++;
        end
        if (got.screen_changed !== want.screen_changed) begin
          $display("%0t: screen_changed expected %b actual %b", $time,
                   want.screen_changed, got.screen_changed);
          fail_count++;
        end
        if (got.waiting_for_key !== want.waiting_for_key) begin
          $display("%0t: waiting_for_key expected %b actual %b", $time,
                   want.waiting_for_key, got.waiting_for_key);
          fail_count++;
        end
        if (got.screen_row !== want.screen_row) begin
          $display("%0t: screen_row expected %h actual %h", $time, want.screen_row,
                   got.screen_row);
          fail_count++;
        end
        if (got.fault !== want.fault) begin
          $display("%0t: fault expected %0d actual %0d", $time, want.fault, got.fault);
          fail_count++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      want = '0;
      if (in_action == c8_pkg::ACT_LOAD) mem_m[in_address] = in_data;
      else if (in_action == c8_pkg::ACT_RUN)
        predict_cycle(in_keys_pressed, in_random_value, want);
      else if (in_action == c8_pkg::ACT_READ && in_address < c8_pkg::SCREEN_ROWS)
        want.screen_row = fb_m[in_address];
      want.pc_now = pc_m;
      want.sound_on = (sound_m != 0);
      result_q.push_back(want);
    end
    pending_count = result_q.size();
  end
endmodule

[verif/tb_chip8_interpreter_core_unit.sv]
module tb_chip8_interpreter_core_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_action = c8_pkg::ACT_LOAD;
  logic [11:0] in_address = '0;
  logic [7:0]  in_data = '0;
  logic [15:0] in_keys_pressed = '0;
  logic [7:0]  in_random_value = '0;
  logic        out_valid;
  logic [11:0] out_pc_now;
  logic        out_sound_on;
  logic        out_screen_changed;
  logic        out_waiting_for_key;
  logic [63:0] out_screen_row;
  logic [1:0]  out_fault;
  int          fail_count;
  int          pending_count;

  localparam int CYCLE_LIMIT = 1_000_000;

  // Stimulus-side knowledge: which bytes hold data, the current PC and I.
  logic        written [c8_pkg::MEM_DEPTH];
  logic [11:0] cur_pc = c8_pkg::PC_START;
  logic [11:0] idx_val = '0;
  logic        idx_known = 1'b1;
  logic        calm = 1'b0;
  int          n_runs = 0, n_loads = 0, n_reads = 0;
  int          cycles = 0;

  localparam logic [7:0] MISC_NN [11] = '{c8_pkg::NN_GETDT, c8_pkg::NN_WAITK,
    c8_pkg::NN_SETDT, c8_pkg::NN_SETST, c8_pkg::NN_ADDIX, c8_pkg::NN_FONT,
    c8_pkg::NN_BCD, c8_pkg::NN_STORE, c8_pkg::NN_LOAD, 8'h00, 8'hff};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  chip8_interpreter_core_unit dut (.*);

  chip8_interpreter_core_checker checker_i (.*);

  task automatic send_request(input logic [1:0] act, input logic [11:0] addr,
                              input logic [7:0] dat, input logic [15:0] keys,
                              input logic [7:0] rnd);
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 9) repeat ($urandom_range(1, 6)) @(negedge clk);
    while (busy) @(negedge clk);
    in_action <= act;
    in_address <= addr;
    in_data <= dat;
    in_keys_pressed <= keys;
    in_random_value <= rnd;
    start <= 1'b1;
    @(negedge clk);
    start <= 1'b0;
    while (!out_valid) @(negedge clk);
    cur_pc = out_pc_now;
    case (act)
      c8_pkg::ACT_LOAD: n_loads++;
      c8_pkg::ACT_RUN:  n_runs++;
      default:          n_reads++;
    endcase
  endtask

  task automatic load_byte(input logic [11:0] addr, input logic [7:0] dat);
    send_request(c8_pkg::ACT_LOAD, addr, dat, 16'($urandom), 8'($urandom));
    written[addr] = 1'b1;
  endtask

  // Places op at the PC, makes sure any bytes it reads through I hold data,
  // then runs one instruction.
  task automatic run_instr(input logic [15:0] op, input logic [15:0] keys);
    int span;
    span = 0;
    if (op[15:12] == c8_pkg::K_DRW) span = op[3:0];
    if (op[15:12] == c8_pkg::K_MISC && op[7:0] == c8_pkg::NN_LOAD) span = op[11:8] + 1;
    if (idx_known) begin
      for (int i = 0; i < span; i++)
        if (!written[idx_val + 12'(i)]) load_byte(idx_val + 12'(i), 8'($urandom));
    end
    load_byte(cur_pc, op[15:8]);
    load_byte(cur_pc + 12'd1, op[7:0]);
    send_request(c8_pkg::ACT_RUN, 12'($urandom), 8'($urandom), keys, 8'($urandom));
    if (op[15:12] == c8_pkg::K_LDIX) begin
      idx_val = op[11:0];
      idx_known = 1'b1;
    end else if (op[15:12] == c8_pkg::K_MISC &&
                 (op[7:0] == c8_pkg::NN_ADDIX || op[7:0] == c8_pkg::NN_FONT))
      idx_known = 1'b0;
  endtask

  function automatic logic [15:0] random_instr();
    logic [15:0] op;
    int pick;
    op = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) op = {c8_pkg::K_CALL, op[11:0]};
    else if (pick < 16) op = c8_pkg::OP_RET;
    case (op[15:12])
      c8_pkg::K_SYS:
        if (pick >= 16) op = ($urandom_range(0, 2) == 0) ? c8_pkg::OP_CLS : op;
      c8_pkg::K_KEY: op[7:0] = $urandom_range(0, 1) ? c8_pkg::NN_SKP : c8_pkg::NN_SKNP;
      c8_pkg::K_MISC: op[7:0] = MISC_NN[$urandom_range(0, 10)];
      default: ;
    endcase
    if (!idx_known && (op[15:12] == c8_pkg::K_DRW ||
                       (op[15:12] == c8_pkg::K_MISC && op[7:0] == c8_pkg::NN_LOAD)))
      op = {c8_pkg::K_LDIX, op[11:0]};
    return op;
  endfunction

  initial begin
    logic [15:0] keys;
    for (int a = 0; a < c8_pkg::MEM_DEPTH; a++) written[a] = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: clipping at both edges, collision, flag cases, key wait, BCD,
    // block moves, jump with offset and stack overflow and underflow.
    run_instr(16'h00ee, 16'h0);
    run_instr(16'h603f, 16'h0);
    run_instr(16'h611f, 16'h0);
    run_instr(16'ha300, 16'h0);
    run_instr(16'hd01f, 16'h0);
    run_instr(16'hd01f, 16'h0);
    send_request(c8_pkg::ACT_READ, 12'd31, 8'h0, 16'h0, 8'h0);
    send_request(c8_pkg::ACT_READ, 12'd32, 8'h0, 16'h0, 8'h0);
    send_request(c8_pkg::ACT_READ, 12'hfff, 8'hff, 16'hffff, 8'hff);
    send_request(2'd3, 12'hfff, 8'hff, 16'hffff, 8'hff);
    load_byte(12'hfff, 8'hff);
    run_instr(16'h62ff, 16'h0);
    run_instr(16'h8324, 16'h0);
    run_instr(16'h8235, 16'h0);
    run_instr(16'h8236, 16'h0);
    run_instr(16'h832e, 16'h0);
    run_instr(16'h8237, 16'h0);
    run_instr(16'hafff, 16'h0);
    run_instr(16'hf21e, 16'h0);
    run_instr(16'hf029, 16'h0);
    run_instr(16'hf233, 16'h0);
    run_instr(16'hf455, 16'h0);
    run_instr(16'hf465, 16'h0);
    run_instr(16'ha300, 16'h0);
    run_instr(16'hff65, 16'h0);
    run_instr(16'hf50a, 16'h0);
    run_instr(16'hf50a, 16'h8000);
    run_instr(16'hf218, 16'h0);
    run_instr(16'hc2ff, 16'hffff);
    run_instr(16'hb2ff, 16'h0);
    for (int i = 0; i < c8_pkg::STACK_DEPTH + 1; i++)
      run_instr({c8_pkg::K_CALL, 12'($urandom)}, 16'h0);
    for (int i = 0; i < c8_pkg::STACK_DEPTH + 1; i++) run_instr(c8_pkg::OP_RET, 16'h0);
    run_instr(c8_pkg::OP_CLS, 16'h0);

    // Random programs, with a calm stretch and some raw traffic mixed in.
    for (int i = 0; i < 330; i++) begin
      calm = (i >= 100 && i < 150);
      keys = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom);
      case ($urandom_range(0, 19))
        0: send_request(c8_pkg::ACT_READ, 12'($urandom_range(0, 40)), 8'($urandom),
                        keys, 8'($urandom));
        1: send_request(c8_pkg::ACT_READ, 12'($urandom), 8'($urandom), keys,
                        8'($urandom));
        2: send_request(2'd3, 12'($urandom), 8'($urandom), keys, 8'($urandom));
        3: load_byte(12'($urandom), 8'($urandom));
        default: run_instr(random_instr(), keys);
      endcase
    end
    calm = 1'b0;

    repeat (50) @(posedge clk);
    $display("ran %0d cycles of the core, %0d byte loads and %0d row reads or other",
             n_runs, n_loads, n_reads);
    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending_count);
      $display("status: fail");
    end
    $finish;
  end
endmodule
